>>> hdl/rastrigin_fitness_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Rastrigin fitness accumulator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef RASTRIGIN_FITNESS_ACCUMULATOR_MACROS_SVH
`define RASTRIGIN_FITNESS_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define RFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Types, constants and the arctangent table of the Rastrigin accumulator.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int FRAC_BITS = 24;
  localparam int CW        = 34;
  localparam int TW        = CW + 5;
  localparam int SW        = 63;
  localparam int TERMW     = 65;
  localparam int COS_SHIFT = 30 - FRAC_BITS;

  localparam logic [CW-1:0]    CORDIC_K = 34'h026DD3B6A;
  localparam logic [SW-1:0]    SUM_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic [TERMW-1:0] TEN_Q    = TERMW'(10) << FRAC_BITS;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic          neg;
    logic [SW-1:0] sq;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } rfa_item_t;

  function automatic logic [31:0] rfa_atan(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/rastrigin_fitness_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rastrigin_fitness_accumulator
// Streams Q8.24 genes and returns the negated Rastrigin sum per solution.
// ----------------------------------------------------------------------------
// One gene is taken every cycle unless the pipe is held. Each gene goes
// through an entry stage that squares it and folds its fractional part into
// a cosine phase, a chain of COS_STAGES CORDIC cells, two stages that form
// x*x - 10*cos + 10, and the saturating accumulator; the result of a last gene
// appears at out_valid. The accumulator's registered running-sum loop sets the
// one-gene-per-cycle rate. The whole pipe holds only while a finished result
// waits at the output and the next last gene reaches the accumulator.
module rastrigin_fitness_accumulator import rfa_pkg::*; #(
  parameter int COS_STAGES = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   gene,
  input  logic                 last_gene,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [SW-1:0] fitness,
  output logic                 saturated
);

  rfa_item_t chain [COS_STAGES+1];
  logic      advance;

  assign in_ready = advance;

  rfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (in_valid),
    .gene      (gene),
    .last_gene (last_gene),
    .q         (chain[0])
  );

  for (genvar i = 0; i < COS_STAGES; i++) begin : g_cell
    rfa_cell #(
      .IDX (i)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  rfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .d         (chain[COS_STAGES]),
    .out_ready (out_ready),
    .advance   (advance),
    .out_valid (out_valid),
    .fitness   (fitness),
    .saturated (saturated)
  );

endmodule

>>> hdl/rfa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_front
// Gene entry stage: registered square, folded cosine phase, CORDIC seed.
// ----------------------------------------------------------------------------
module rfa_front import rfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] gene,
  input  logic               last_gene,
  output rfa_item_t          q
);

  logic signed [63:0] prod;
  logic [31:0]        angle;
  logic               fold;
  logic [31:0]        afold;

  assign prod  = gene * gene;
  assign angle = {gene[FRAC_BITS-1:0], (32-FRAC_BITS)'(0)};
  assign fold  = angle[31] ^ angle[30];
  assign afold = {angle[31] ^ fold, angle[30:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= in_valid;
    end
    if (en) begin
      q.last <= last_gene;
      q.neg  <= fold;
      q.sq   <= SW'(prod >> FRAC_BITS);
      q.x    <= CORDIC_K;
      q.y    <= '0;
      q.z    <= {{(CW-32){afold[31]}}, afold};
    end
  end

endmodule

>>> hdl/rfa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_cell
// One CORDIC rotation stage; passes the gene's side data to the next cell.
// ----------------------------------------------------------------------------
module rfa_cell import rfa_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  rfa_item_t d,
  output rfa_item_t q
);

  logic signed [CW-1:0] xs, ys, zs, xsh, ysh, at, nx, ny, nz;

  always_comb begin
    xs  = $signed(d.x);
    ys  = $signed(d.y);
    zs  = $signed(d.z);
    xsh = xs >>> IDX;
    ysh = ys >>> IDX;
    at  = $signed({{(CW-32){1'b0}}, rfa_atan(5'(IDX))});
    if (!zs[CW-1]) begin
      nx = xs - ysh;
      ny = ys + xsh;
      nz = zs - at;
    end else begin
      nx = xs + ysh;
      ny = ys - xsh;
      nz = zs + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.last <= d.last;
      q.neg  <= d.neg;
      q.sq   <= d.sq;
      q.x    <= nx;
      q.y    <= ny;
      q.z    <= nz;
    end
  end

endmodule

>>> hdl/rfa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_back
// Cosine scaling, per-gene term, saturating running sum and result register.
// ----------------------------------------------------------------------------
module rfa_back import rfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rfa_item_t            d,
  input  logic                 out_ready,
  output logic                 advance,
  output logic                 out_valid,
  output logic signed [SW-1:0] fitness,
  output logic                 saturated
);

  logic                    b1_valid, b1_last;
  logic [SW-1:0]           b1_sq;
  logic signed [TW-1:0]    b1_tencos;
  logic                    b2_valid, b2_last;
  logic signed [TERMW-1:0] b2_term;
  logic [SW-1:0]           running_sum;
  logic                    overflow_seen;

  logic signed [CW:0]      cval;
  logic signed [TW-1:0]    cw, ten;
  logic signed [TERMW-1:0] sum;
  logic [SW-1:0]           sum_next;
  logic                    flag_next;

  assign advance = !(b2_valid && b2_last && out_valid && !out_ready);

  always_comb begin
    cval = d.neg ? -$signed({d.x[CW-1], d.x}) : $signed({d.x[CW-1], d.x});
    cw   = {{(TW-CW-1){cval[CW]}}, cval};
    ten  = (cw <<< 3) + (cw <<< 1);
  end

  always_comb begin
    sum       = $signed({2'b00, running_sum}) + b2_term;
    sum_next  = sum[SW-1:0];
    flag_next = overflow_seen;
    if (sum[TERMW-1]) begin
      sum_next = '0;
    end else if (sum > $signed({2'b00, SUM_MAX})) begin
      sum_next  = SUM_MAX;
      flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid      <= 1'b0;
      b2_valid      <= 1'b0;
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance && b2_valid && b2_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        b1_valid <= d.valid;
        b2_valid <= b1_valid;
        if (b2_valid) begin
          if (b2_last) begin
            running_sum   <= '0;
            overflow_seen <= 1'b0;
          end else begin
            running_sum   <= sum_next;
            overflow_seen <= flag_next;
          end
        end
      end
    end
    if (advance) begin
      b1_last   <= d.last;
      b1_sq     <= d.sq;
      b1_tencos <= ten >>> COS_SHIFT;
      b2_last   <= b1_last;
      b2_term   <= $signed({2'b00, b1_sq}) - {{(TERMW-TW){b1_tencos[TW-1]}}, b1_tencos}
                   + $signed(TEN_Q);
      if (b2_valid && b2_last) begin
        fitness   <= -$signed(sum_next);
        saturated <= flag_next;
      end
    end
  end

endmodule

>>> hdl/rfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks of the Rastrigin accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rastrigin_fitness_accumulator_macros.svh"

module rfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [62:0] fitness,
  input logic        saturated
);

  `RFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `RFA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(fitness) && $stable(saturated), "result changed while stalled")
  `RFA_ASSERT_NOW(a_fit_sign, out_valid, fitness == 63'd0 || fitness[62], "fitness is positive")
  `RFA_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready, "input held without output stall")

endmodule

bind rastrigin_fitness_accumulator rfa_checker u_rfa_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams Q8.24 genes into the Rastrigin accumulator and checks each
// solution's negated sum and saturation flag against a bit-exact CORDIC
// predictor, with random idle bursts on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
  import rfa_pkg::*;

  localparam int CORDIC_STAGES = 24;
  localparam int RANDOM_GENES  = 1150;
  localparam int TAIL_GENES    = 150;
  localparam int DRAIN_CYCLES  = CORDIC_STAGES + 16;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [31:0] gene;
    logic        last;
  } gene_req_t;

  typedef struct packed {
    logic [SW-1:0] fitness;
    logic          saturated;
  } fitness_rec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   gene = '0;
  logic                 last_gene = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] fitness;
  logic                 saturated;

  gene_req_t    gene_queue [$];
  fitness_rec_t fitness_due [$];
  longint       solution_sum = 0;
  bit           solution_sat = 1'b0;
  int           genes_total = 0;
  int           genes_taken = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           errors = 0;

  rastrigin_fitness_accumulator #(
    .COS_STAGES(CORDIC_STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .gene(gene),
    .last_gene(last_gene),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fitness(fitness),
    .saturated(saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit calm_tail();
    return gene_queue.size() < TAIL_GENES;
  endfunction

  // cos(2*pi*angle/2^32) in Q1.30
  function automatic longint cos_turns(logic [31:0] angle);
    longint cx, cy, cz, nx;
    bit     flip;
    int     i;
    flip = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    if (flip) angle = angle + 32'h80000000;
    cx = longint'(CORDIC_K);
    cy = 0;
    cz = longint'($signed(angle));
    for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz = cz - longint'(ATAN_TURNS[i]);
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz = cz + longint'(ATAN_TURNS[i]);
      end
      cx = nx;
    end
    return flip ? -cx : cx;
  endfunction

  function automatic longint rastrigin_term(logic [31:0] g);
    longint      xv, mag, sq, tencos;
    logic [31:0] phase;
    xv = longint'($signed(g));
    mag = (xv < 0) ? -xv : xv;
    sq = (mag * mag) >> FRAC_BITS;
    phase = 32'(g[FRAC_BITS-1:0]) << (32 - FRAC_BITS);
    tencos = (longint'(10) * cos_turns(phase)) >>> (30 - FRAC_BITS);
    return sq - tencos + (longint'(10) << FRAC_BITS);
  endfunction

  function automatic void accumulate_gene(logic [31:0] g, logic last);
    longint       sum;
    fitness_rec_t rec;
    sum = solution_sum + rastrigin_term(g);
    if (sum < 0) sum = 0;
    if (sum > longint'(SUM_MAX)) begin
      sum = longint'(SUM_MAX);
      solution_sat = 1'b1;
    end
    solution_sum = sum;
    if (last) begin
      rec.fitness = SW'(-sum);
      rec.saturated = solution_sat;
      fitness_due.push_back(rec);
      solution_sum = 0;
      solution_sat = 1'b0;
    end
  endfunction

  function automatic logic [31:0] random_gene();
    logic [31:0] g;
    int          kind;
    kind = $urandom_range(0, 9);
    case (kind) inside
      [0:3]: g = 32'($urandom_range(0, 171798690)) - 32'd85899345;
      [4:5]: g = $urandom;
      6: begin
        g = {8'($urandom_range(0, 255)), 24'h0};
        case ($urandom_range(0, 7))
          0: g[23:0] = 24'h000000;
          1: g[23:0] = 24'h400000;
          2: g[23:0] = 24'h800000;
          3: g[23:0] = 24'hC00000;
          4: g[23:0] = 24'h3FFFFF;
          5: g[23:0] = 24'h7FFFFF;
          6: g[23:0] = 24'hBFFFFF;
          default: g[23:0] = 24'hFFFFFF;
        endcase
      end
      default: g = 32'($urandom_range(0, 33554432)) - 32'd16777216;
    endcase
    return g;
  endfunction

  task automatic add_gene(logic [31:0] g, logic last);
    gene_req_t req;
    req.gene = g;
    req.last = last;
    gene_queue.push_back(req);
    genes_total++;
  endtask

  // request driver and predictor feed
  always @(posedge clk) begin
    gene_req_t req;
    bit        go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_gene(gene, last_gene);
        genes_taken++;
      end
      if (!in_valid || in_ready) begin
        go = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (gene_queue.size() > 0) begin
          if (!calm_tail() && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 13) - 1;
          end else begin
            go = 1'b1;
          end
        end
        if (go) begin
          req = gene_queue.pop_front();
          gene <= req.gene;
          last_gene <= req.last;
        end
        in_valid <= go;
      end
    end
  end

  // result monitor and output stalls
  always @(posedge clk) begin
    fitness_rec_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fitness_due.size() == 0) begin
          $display("%0t: unexpected result fitness=%h saturated=%b",
                   $time, fitness, saturated);
          errors++;
        end else begin
          want = fitness_due.pop_front();
          if (fitness !== want.fitness) begin
            $display("%0t: fitness mismatch expected %h actual %h",
                     $time, want.fitness, fitness);
            errors++;
          end
          if (saturated !== want.saturated) begin
            $display("%0t: saturated mismatch expected %b actual %b",
                     $time, want.saturated, saturated);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm_tail() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    int len;
    int k;
    // extremes, quadrant edges, one-gene solutions, clamp at zero
    add_gene(32'h00000000, 1'b1);
    add_gene(32'h7FFFFFFF, 1'b1);
    add_gene(32'h80000000, 1'b1);
    add_gene(32'h7FFFFFFF, 1'b0);
    add_gene(32'h80000000, 1'b0);
    add_gene(32'h7FFFFFFF, 1'b1);
    add_gene(32'h00000001, 1'b0);
    add_gene(32'hFFFFFFFF, 1'b0);
    add_gene(32'h00400000, 1'b0);
    add_gene(32'h003FFFFF, 1'b0);
    add_gene(32'h00800000, 1'b0);
    add_gene(32'h00BFFFFF, 1'b0);
    add_gene(32'h00C00000, 1'b1);
    add_gene(32'h01000000, 1'b0);
    add_gene(32'hFF000000, 1'b0);
    add_gene(32'h00FFFFFF, 1'b0);
    add_gene(32'hFF800000, 1'b1);
    add_gene(32'h051EB851, 1'b0);
    add_gene(32'hFAE147AF, 1'b1);
    add_gene(32'h00000000, 1'b0);
    add_gene(32'h00000000, 1'b0);
    add_gene(32'h00000000, 1'b1);
    sent = 0;
    while (sent < RANDOM_GENES) begin
      if ($urandom_range(0, 9) < 8) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 40);
      for (k = 0; k < len; k++) begin
        add_gene(random_gene(), k == len - 1);
      end
      sent += len;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(posedge clk);
    end while (genes_taken != genes_total || fitness_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && fitness_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("testbench failed");
    $finish;
  end

endmodule
